/* design/base64_stream_decoder_core_macros.svh */
// Assertion macros for the base64 stream decoder.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
`define BSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BSD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) else $error(msg);
`else
`define BSD_ASSERT(label, prop, msg)
`define BSD_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* design/bsd_pkg.sv */
package bsd_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int HELD_W   = 18;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    // Held sextet counts
    localparam logic [1:0] CNT_ZERO  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Index of the final byte within a job
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD  = 2'd2;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } t_sextet;

    // One unit of work for the back end: up to three bytes to emit
    typedef struct packed {
        logic [CHAR_W-1:0] b0;
        logic [CHAR_W-1:0] b1;
        logic [CHAR_W-1:0] b2;
        logic [1:0]        last_idx;
        logic              byte_valid;
        logic              last;
    } t_job;

    typedef struct packed {
        logic [1:0] sextet_count;
        logic       stopped;
    } t_front_status;

    function automatic t_sextet sextet_of(logic [CHAR_W-1:0] c);
        t_sextet r;
        r.ok    = 1'b1;
        r.value = '0;
        if (c inside {[8'h41:8'h5A]}) begin        // A..Z
            r.value = SEXTET_W'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin // a..z
            r.value = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin // 0..9
            r.value = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if (c inside {8'h2B, 8'h2D}) begin  // plus, minus
            r.value = 6'd62;
        end else if (c inside {8'h2F, 8'h5F}) begin  // slash, underscore
            r.value = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

/* design/bsd_in_if.sv */
interface bsd_in_if;
    logic                       valid;
    logic                       ready;
    logic [bsd_pkg::CHAR_W-1:0] in_char;
    logic                       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

/* design/bsd_cfg_if.sv */
interface bsd_cfg_if;
    logic valid;
    logic ready;
    logic skip_invalid;

    modport source (output valid, output skip_invalid, input ready);
    modport sink   (input valid, input skip_invalid, output ready);
endinterface

/* design/bsd_out_if.sv */
interface bsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsd_pkg::CHAR_W-1:0] data_byte;
    logic                       byte_valid;
    logic                       last;

    modport source (output valid, output data_byte, output byte_valid, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last,
                    output ready);
endinterface

/* design/base64_stream_decoder_core.sv */
// Flow: a completing character's job is written into the queue when the character transfers, and
//   the back end offers its first byte once it has loaded the job; an end-of-text result goes the same way.
// Throughput: one character per cycle in; one result per cycle out while work is queued and the output is ready;
//   input stalls only when the job queue between the front and back ends is full (QUEUE_DEPTH jobs).
// Reset: synchronous, active low; clears decode state, the queue, and skip_invalid.
`include "base64_stream_decoder_core_macros.svh"

module base64_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsd_in_if.sink    i_text,
    bsd_cfg_if.sink   i_cfg,
    bsd_out_if.source o_bytes
);

    // Configuration: a single bit, always ready. Write it only while no character
    // is in flight; the front end reads it at the transfer of each character.
    logic r_skip;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_skip <= i_cfg.skip_invalid;
        end
    end

    // Front end: map each character to a sextet, track the held group and the
    // stopped flag, and emit one job per completed group or per end of text.
    logic                   push;
    bsd_pkg::t_job          push_job;
    bsd_pkg::t_front_status front_status;

    // Queue: decouples the front end from output back pressure.
    logic          pop;
    bsd_pkg::t_job pop_job;
    logic          q_full;
    logic          q_empty;

    bsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_skip   (r_skip),
        .i_q_full (q_full),
        .i_text   (i_text),
        .o_push   (push),
        .o_job    (push_job),
        .o_status (front_status)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: hold one job and advance through its bytes, one transfer per cycle while o_bytes.ready is high.
    // The next job is loaded in the same cycle the final byte of the current one
    // transfers, so the output never bubbles while work is queued.
    bsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (pop_job),
        .o_pop     (pop),
        .o_bytes   (o_bytes)
    );

    // Checks
    `BSD_ASSERT(a_no_push_when_full, push |-> !q_full, "job pushed into a full queue")
    `BSD_ASSERT(a_eot_makes_job, (i_text.valid && i_text.ready && i_text.end_of_text) |-> push, "end of text produced no job")
    `BSD_ASSERT(a_marker_is_last, (o_bytes.valid && !o_bytes.byte_valid) |-> o_bytes.last, "bare marker without last")
    `BSD_ASSERT_NEXT(a_eot_clears, (i_text.valid && i_text.ready && i_text.end_of_text), (front_status.sextet_count == bsd_pkg::CNT_ZERO && !front_status.stopped), "state not cleared after end of text")

endmodule

/* design/bsd_front.sv */
module bsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_skip,
    input  logic                   i_q_full,
    bsd_in_if.sink                 i_text,
    output logic                   o_push,
    output bsd_pkg::t_job          o_job,
    output bsd_pkg::t_front_status o_status
);

    logic [1:0]                   r_cnt, n_cnt;
    logic [bsd_pkg::HELD_W-1:0]   r_held, n_held;
    logic                         r_stop, n_stop;
    logic                         accept;
    logic                         group_done;
    logic [bsd_pkg::HELD_W+bsd_pkg::SEXTET_W-1:0] word;
    bsd_pkg::t_sextet             sx;

    assign i_text.ready = !i_q_full;
    assign accept       = i_text.valid && i_text.ready;
    assign sx           = bsd_pkg::sextet_of(i_text.in_char);
    assign word         = {r_held, sx.value};

    always_comb begin
        n_cnt      = r_cnt;
        n_held     = r_held;
        n_stop     = r_stop;
        group_done = 1'b0;

        if (!r_stop) begin
            if (i_text.in_char == bsd_pkg::CHAR_NUL) begin
                n_stop = 1'b1;
            end else if (!sx.ok) begin
                if (!i_skip) begin
                    n_stop = 1'b1;
                end
            end else if (r_cnt == bsd_pkg::CNT_THREE) begin
                group_done = 1'b1;
                n_cnt      = bsd_pkg::CNT_ZERO;
                n_held     = '0;
            end else begin
                n_held = {r_held[bsd_pkg::HELD_W-bsd_pkg::SEXTET_W-1:0], sx.value};
                n_cnt  = r_cnt + 2'd1;
            end
        end

        // Build the job: a full group, else a flush at end of text, else a bare marker
        o_job.b0         = '0;
        o_job.b1         = '0;
        o_job.b2         = '0;
        o_job.last_idx   = bsd_pkg::IDX_FIRST;
        o_job.byte_valid = 1'b1;
        o_job.last       = i_text.end_of_text;
        if (group_done) begin
            o_job.b0       = word[23:16];
            o_job.b1       = word[15:8];
            o_job.b2       = word[7:0];
            o_job.last_idx = bsd_pkg::IDX_THIRD;
        end else if (n_cnt == bsd_pkg::CNT_THREE) begin
            o_job.b0       = n_held[17:10];
            o_job.b1       = n_held[9:2];
            o_job.last_idx = bsd_pkg::IDX_SECOND;
        end else if (n_cnt == bsd_pkg::CNT_TWO) begin
            o_job.b0 = n_held[11:4];
        end else begin
            o_job.byte_valid = 1'b0;
        end

        o_push = accept && (group_done || i_text.end_of_text);

        // End of text clears everything
        if (i_text.end_of_text) begin
            n_cnt  = bsd_pkg::CNT_ZERO;
            n_held = '0;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= bsd_pkg::CNT_ZERO;
            r_held <= '0;
            r_stop <= 1'b0;
        end else if (accept) begin
            r_cnt  <= n_cnt;
            r_held <= n_held;
            r_stop <= n_stop;
        end
    end

    assign o_status.sextet_count = r_cnt;
    assign o_status.stopped      = r_stop;

endmodule

/* design/bsd_queue.sv */
module bsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsd_pkg::t_job i_data,
    input  logic          i_pop,
    output bsd_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsd_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* design/bsd_back.sv */
module bsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  bsd_pkg::t_job i_q_data,
    output logic          o_pop,
    bsd_out_if.source     o_bytes
);

    logic          r_busy;
    bsd_pkg::t_job r_job;
    logic [1:0]    r_idx;
    logic          xfer;
    logic          at_end;

    assign xfer   = o_bytes.valid && o_bytes.ready;
    assign at_end = (r_idx == r_job.last_idx);
    assign o_pop  = !i_q_empty && (!r_busy || (xfer && at_end));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= bsd_pkg::IDX_FIRST;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= bsd_pkg::IDX_FIRST;
        end else if (xfer && at_end) begin
            r_busy <= 1'b0;
        end else if (xfer) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_comb begin
        case (r_idx)
            bsd_pkg::IDX_FIRST:  o_bytes.data_byte = r_job.b0;
            bsd_pkg::IDX_SECOND: o_bytes.data_byte = r_job.b1;
            default:             o_bytes.data_byte = r_job.b2;
        endcase
    end

    assign o_bytes.valid      = r_busy;
    assign o_bytes.byte_valid = r_job.byte_valid;
    assign o_bytes.last       = r_job.last && at_end;

endmodule

/* tb/sv/bsd_byte_checker.sv */
`timescale 1ns / 1ps

// Watch the three channels, predict the decoded bytes of every accepted
// character, and compare each accepted result with the oldest prediction.
module bsd_byte_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bsd_in_if    text_bus,
    bsd_cfg_if   cfg_bus,
    bsd_out_if   byte_bus,
    output int   o_error_count,
    output int   o_pending,
    output int   o_item_count,
    output int   o_result_count
);

    localparam int CHAR_W   = bsd_pkg::CHAR_W;
    localparam int SEXTET_W = bsd_pkg::SEXTET_W;
    localparam int HELD_W   = bsd_pkg::HELD_W;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = "A";
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = "Z";
    localparam logic [CHAR_W-1:0] CH_LOWER_A = "a";
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = "z";
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = "0";
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = "9";
    localparam logic [CHAR_W-1:0] CH_PLUS    = "+";
    localparam logic [CHAR_W-1:0] CH_MINUS   = "-";
    localparam logic [CHAR_W-1:0] CH_SLASH   = "/";
    localparam logic [CHAR_W-1:0] CH_UNDER   = "_";
    localparam logic [SEXTET_W-1:0] SEXTET_62 = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_63 = 6'd63;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              byte_valid;
        logic              last;
    } t_byte_result;

    t_byte_result        expected_bytes_q [$];
    logic [1:0]          held_count;
    logic [HELD_W-1:0]   held_bits;
    logic                halted;
    logic                skip_mode;
    int                  error_count;
    int                  pending_count;
    int                  item_count;
    int                  result_count;

    assign o_error_count  = error_count;
    assign o_pending      = pending_count;
    assign o_item_count   = item_count;
    assign o_result_count = result_count;

    function automatic bsd_pkg::t_sextet alphabet_lookup(logic [CHAR_W-1:0] c);
        bsd_pkg::t_sextet s;
        s.ok    = 1'b1;
        s.value = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            s.value = SEXTET_W'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            s.value = SEXTET_W'(c - CH_LOWER_A + 8'd26);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            s.value = SEXTET_W'(c - CH_DIGIT_0 + 8'd52);
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            s.value = SEXTET_62;
        end else if (c == CH_SLASH || c == CH_UNDER) begin
            s.value = SEXTET_63;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    function automatic void predict_bytes(logic [CHAR_W-1:0] c, logic eot);
        logic [CHAR_W-1:0] out_b [3];
        logic [23:0]       word;
        bsd_pkg::t_sextet  s;
        int                n;
        n = 0;
        word = '0;
        out_b[0] = '0;
        out_b[1] = '0;
        out_b[2] = '0;
        if (!halted) begin
            if (c == bsd_pkg::CHAR_NUL) begin
                halted = 1'b1;
            end else begin
                s = alphabet_lookup(c);
                if (!s.ok) begin
                    if (!skip_mode) halted = 1'b1;
                end else if (held_count == bsd_pkg::CNT_THREE) begin
                    word = {held_bits, s.value};
                    out_b[0] = word[23:16];
                    out_b[1] = word[15:8];
                    out_b[2] = word[7:0];
                    n = 3;
                    held_count = bsd_pkg::CNT_ZERO;
                    held_bits = '0;
                end else begin
                    held_bits = {held_bits[HELD_W-SEXTET_W-1:0], s.value};
                    held_count = held_count + 2'd1;
                end
            end
        end
        if (eot) begin
            // flush a partial group; one sextet alone carries no byte
            if (n == 0) begin
                if (held_count == bsd_pkg::CNT_THREE) begin
                    out_b[0] = held_bits[17:10];
                    out_b[1] = held_bits[9:2];
                    n = 2;
                end else if (held_count == bsd_pkg::CNT_TWO) begin
                    out_b[0] = held_bits[11:4];
                    n = 1;
                end
            end
            if (n == 0) begin
                expected_bytes_q.push_back('{data_byte: '0, byte_valid: 1'b0, last: 1'b1});
            end else begin
                for (int k = 0; k < n; k++) begin
                    expected_bytes_q.push_back('{data_byte: out_b[k], byte_valid: 1'b1,
                                                 last: (k == n - 1)});
                end
            end
            held_count = bsd_pkg::CNT_ZERO;
            held_bits = '0;
            halted = 1'b0;
        end else begin
            for (int k = 0; k < n; k++) begin
                expected_bytes_q.push_back('{data_byte: out_b[k], byte_valid: 1'b1,
                                             last: 1'b0});
            end
        end
    endfunction

    function automatic void note_error(string msg);
        if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endfunction

    always @(posedge i_clk) begin
        t_byte_result got;
        t_byte_result want;
        if (!i_rst_n) begin
            expected_bytes_q.delete();
            held_count    = bsd_pkg::CNT_ZERO;
            held_bits     = '0;
            halted        = 1'b0;
            skip_mode     = 1'b0;
            error_count   = 0;
            pending_count = 0;
            item_count    = 0;
            result_count  = 0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) skip_mode = cfg_bus.skip_invalid;
            if (text_bus.valid && text_bus.ready) begin
                predict_bytes(text_bus.in_char, text_bus.end_of_text);
                item_count++;
            end
            if (byte_bus.valid && byte_bus.ready) begin
                got = '{data_byte: byte_bus.data_byte, byte_valid: byte_bus.byte_valid,
                        last: byte_bus.last};
                result_count++;
                if (expected_bytes_q.size() == 0) begin
                    note_error($sformatf("unexpected result byte=%02h valid=%b last=%b",
                                         got.data_byte, got.byte_valid, got.last));
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid
                        || got.last !== want.last) begin
                        note_error($sformatf(
                            "result %0d expected byte=%02h valid=%b last=%b, got %02h %b %b",
                            result_count, want.data_byte, want.byte_valid, want.last,
                            got.data_byte, got.byte_valid, got.last));
                    end
                end
            end
            pending_count = expected_bytes_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Drive character texts into the base64 stream decoder and give the verdict.
// The checker beside the block predicts and compares every result byte.
module tb_top;

    localparam int CHAR_W        = bsd_pkg::CHAR_W;
    localparam int RANDOM_ITEMS  = 180;   // random characters, split over four phases
    localparam int DRAIN_CYCLES  = 10;    // quiet cycles after the last expected result
    localparam int STALL_CYCLES  = 150;   // one long output hold-off
    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_GAP       = 10;

    localparam logic [CHAR_W-1:0] CH_PAD  = "=";
    localparam logic [CHAR_W-1:0] CH_HIGH = 8'h80;
    localparam logic [CHAR_W-1:0] CH_TOP  = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;

    bsd_in_if  text_if ();
    bsd_cfg_if cfg_if ();
    bsd_out_if bytes_if ();

    int  error_count;
    int  pending;
    int  item_count;
    int  result_count;
    int  text_count;
    int  cfg_writes;
    int  random_items;
    int  cycle_count;
    bit  sender_idle;
    bit  receiver_idle;
    bit  hold_request;
    bit  hold_taken;
    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-_";

    always #4 clk = ~clk;

    base64_stream_decoder_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_if),
        .i_cfg   (cfg_if),
        .o_bytes (bytes_if)
    );

    bsd_byte_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .text_bus       (text_if),
        .cfg_bus        (cfg_if),
        .byte_bus       (bytes_if),
        .o_error_count  (error_count),
        .o_pending      (pending),
        .o_item_count   (item_count),
        .o_result_count (result_count)
    );

    // Offer one character; return once it has transferred. A zero gap keeps
    // valid high straight into the next character.
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic eot);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_if.valid       <= 1'b1;
        text_if.in_char     <= c;
        text_if.end_of_text <= eot;
        do @(posedge clk); while (!text_if.ready);
        if (eot) text_count++;
    endtask

    // Send a whole text, end of text on its last character.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endtask

    // Drop valid, wait for every predicted result, then give the block time
    // to finish characters that produce nothing.
    task automatic wait_drained();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write skip_invalid while the block is idle.
    task automatic write_skip(input logic value);
        wait_drained();
        cfg_if.valid        <= 1'b1;
        cfg_if.skip_invalid <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
    endtask

    // Build one random text. Most are well formed: whole groups, a partial
    // tail and optional padding. The rest get noise characters (any code,
    // zero included) mixed in, and some end on an extra stray character.
    task automatic send_random_text();
        logic [CHAR_W-1:0] chars [$];
        int                n_sextets;
        int                style;
        style     = $urandom_range(0, 9);
        n_sextets = 4 * $urandom_range(0, 2) + $urandom_range(0, 3);
        for (int i = 0; i < n_sextets; i++) begin
            chars.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            if (style >= 7 && $urandom_range(0, 3) == 0) begin
                chars.push_back((style == 9 && $urandom_range(0, 1) == 0)
                                ? bsd_pkg::CHAR_NUL : CHAR_W'($urandom_range(0, 255)));
            end
        end
        if (style < 5 && n_sextets % 4 >= 2) begin
            while (chars.size() % 4 != 0) chars.push_back(CH_PAD);
        end
        if (chars.size() == 0 || $urandom_range(0, 4) == 0) begin
            chars.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        for (int i = 0; i < chars.size(); i++) push_char(chars[i], i == chars.size() - 1);
        random_items += chars.size();
    endtask

    // Result side: draw a gap before every result, hold off once for a long
    // stretch when asked, then wait for the transfer.
    initial begin : result_drain
        int gap;
        bytes_if.ready <= 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_request && !hold_taken) begin
                bytes_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                hold_taken = 1'b1;
            end else begin
                gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
                if (gap > 0) begin
                    bytes_if.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            bytes_if.ready <= 1'b1;
            do @(posedge clk); while (!bytes_if.valid);
        end
    end

    // Abort a run that hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        rst_n                <= 1'b0;
        text_if.valid        <= 1'b0;
        text_if.in_char      <= '0;
        text_if.end_of_text  <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.skip_invalid  <= 1'b0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_request  = 1'b0;
        text_count    = 0;
        cfg_writes    = 0;
        random_items  = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts, invalid characters stop decoding.
        write_skip(1'b0);
        send_text("TWFu");          // group completed on the end character
        send_text("TWE=");          // pad stops decoding, flush two bytes
        send_text("T");             // lone sextet dropped, bare end marker
        push_char(bsd_pkg::CHAR_NUL, 1'b1);  // empty text ending on a zero character
        push_char("A", 1'b0);
        push_char("z", 1'b0);
        push_char(CH_TOP, 1'b1);    // high code stops, flush one byte
        send_text("-_+/");          // both forms of 62 and 63

        // Directed texts, invalid characters skipped.
        write_skip(1'b1);
        push_char("0", 1'b0);
        push_char("9", 1'b0);
        push_char(CH_HIGH, 1'b0);
        push_char(CH_PAD, 1'b0);
        push_char("Z", 1'b0);
        push_char("a", 1'b1);
        push_char("A", 1'b0);
        push_char("B", 1'b0);
        push_char(bsd_pkg::CHAR_NUL, 1'b0);  // zero still stops in skip mode
        push_char("C", 1'b1);

        // Random phases: alternate the register, vary idling, and in the
        // second phase stall the output while the sender runs flat out.
        for (int ph = 0; ph < 4; ph++) begin
            write_skip(ph % 2 == 1);
            sender_idle   = (ph != 1);
            receiver_idle = (ph != 2);
            if (ph == 1) hold_request = 1'b1;
            phase_end = random_items + RANDOM_ITEMS / 4;
            while (random_items < phase_end) send_random_text();
        end

        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d characters in %0d texts, %0d results checked.",
                 item_count, text_count, result_count);
        $display("Skip mode written %0d times both ways; output held off once for %0d cycles.",
                 cfg_writes, STALL_CYCLES);
        if (error_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results never arrived", error_count, pending);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/bsd_pkg.sv
design/bsd_in_if.sv
design/bsd_cfg_if.sv
design/bsd_out_if.sv
design/bsd_front.sv
design/bsd_queue.sv
design/bsd_back.sv
design/base64_stream_decoder_core.sv
tb/sv/bsd_byte_checker.sv
tb/sv/tb_top.sv
